/* rtl/core/bsc_pkg.sv */
package bsc_pkg;

    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;
    localparam int DEN_BASE     = 40500;
    localparam int NUM_SHIFT    = 2;     // numerator gain of 4

    localparam int RADIUS_W = 17;
    localparam int OUT_W    = 17;
    localparam int RED_W    = 8;         // reduced angle, 0..180
    localparam int REM_W    = 9;         // remainder before correction, 0..359
    localparam int PROD_W   = 13;        // t*(180-t) <= 8100
    localparam int DEN_W    = 16;        // 32400..40500
    localparam int MAG_W    = 17;        // |radius| <= 65536
    localparam int NUM_W    = 32;        // |num| < 2^31
    localparam int QUO_W    = 17;        // |quotient| <= 65536
    localparam int SUM_W    = 18;

    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    typedef struct packed {
        logic                       flip;
        logic signed [RADIUS_W-1:0] radius;
        logic        [RED_W-1:0]    angle;
    } t_red_word;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] num_mag;
        logic [DEN_W-1:0] den;
    } t_frac_word;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } t_div_word;

endpackage

/* rtl/core/bsc_reduce.sv */
module bsc_reduce #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic                              i_op,
    input  logic signed [bsc_pkg::RADIUS_W-1:0] i_radius,
    input  logic signed [ANGLE_WIDTH-1:0]     i_angle,
    output logic                              o_valid,
    output bsc_pkg::t_red_word                o_word
);

    localparam int TW          = ANGLE_WIDTH + 1;
    localparam int NW          = ANGLE_WIDTH + 1;
    localparam int MW          = NW - 2;
    localparam int RECIP_SHIFT = NW + 5;
    localparam int RECIP_W     = NW + 1;
    localparam int QW          = NW - 6;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd45);

    // stage 1: cosine offset, fold count argument
    logic signed [TW-1:0] t_ext;
    logic signed [TW-1:0] n_t;
    logic                 n_neg;
    logic                 n_big;
    logic [NW-1:0]        n_n;

    logic                             r1_valid;
    logic signed [bsc_pkg::RADIUS_W-1:0] r1_radius;
    logic [bsc_pkg::RED_W-1:0]        r1_tlow;
    logic                             r1_neg;
    logic                             r1_big;
    logic [NW-1:0]                    r1_n;

    assign t_ext = TW'(i_angle);
    assign n_t   = (i_op == bsc_pkg::OP_COSINE) ?
                   (TW'(bsc_pkg::QUARTER_TURN) - t_ext) : t_ext;
    assign n_neg = n_t[TW-1];
    assign n_big = !n_neg && (n_t > TW'(bsc_pkg::HALF_TURN));

    always_comb begin
        if (n_neg) begin
            n_n = NW'(TW'(bsc_pkg::HALF_TURN - 1) - n_t);
        end else if (n_big) begin
            n_n = NW'(n_t - TW'(1));
        end else begin
            n_n = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_radius <= i_radius;
            r1_tlow   <= n_t[bsc_pkg::RED_W-1:0];
            r1_neg    <= n_neg;
            r1_big    <= n_big;
            r1_n      <= n_n;
        end
    end

    // stage 2: reciprocal multiply, n/180 = (n/4)/45
    logic                             r2_valid;
    logic signed [bsc_pkg::RADIUS_W-1:0] r2_radius;
    logic [bsc_pkg::RED_W-1:0]        r2_tlow;
    logic                             r2_neg;
    logic                             r2_big;
    logic [NW-1:0]                    r2_n;
    logic [MW+RECIP_W-1:0]            r2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_radius <= r1_radius;
            r2_tlow   <= r1_tlow;
            r2_neg    <= r1_neg;
            r2_big    <= r1_big;
            r2_n      <= r1_n;
            r2_prod   <= (MW+RECIP_W)'(r1_n[NW-1:2]) * (MW+RECIP_W)'(RECIP);
        end
    end

    // stage 3: estimate may be one low; form remainder
    logic [QW-1:0] q0;
    logic [NW-1:0] rem_full;

    assign q0       = r2_prod[MW+RECIP_W-1:RECIP_SHIFT];
    assign rem_full = r2_n - NW'(q0) * NW'(bsc_pkg::HALF_TURN);

    logic                             r3_valid;
    logic signed [bsc_pkg::RADIUS_W-1:0] r3_radius;
    logic [bsc_pkg::RED_W-1:0]        r3_tlow;
    logic                             r3_neg;
    logic                             r3_big;
    logic                             r3_qlsb;
    logic [bsc_pkg::REM_W-1:0]        r3_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_radius <= r2_radius;
            r3_tlow   <= r2_tlow;
            r3_neg    <= r2_neg;
            r3_big    <= r2_big;
            r3_qlsb   <= q0[0];
            r3_rem    <= rem_full[bsc_pkg::REM_W-1:0];
        end
    end

    // stage 4: correct, fold angle
    logic                        corr;
    logic [bsc_pkg::REM_W-1:0]   rem_fix;
    logic [bsc_pkg::RED_W-1:0]   rem_low;
    bsc_pkg::t_red_word          n_word;

    assign corr    = r3_rem >= bsc_pkg::REM_W'(bsc_pkg::HALF_TURN);
    assign rem_fix = corr ? (r3_rem - bsc_pkg::REM_W'(bsc_pkg::HALF_TURN)) : r3_rem;
    assign rem_low = rem_fix[bsc_pkg::RED_W-1:0];

    always_comb begin
        n_word.radius = r3_radius;
        n_word.flip   = (r3_neg || r3_big) && (r3_qlsb ^ corr);
        if (r3_neg) begin
            n_word.angle = bsc_pkg::RED_W'(bsc_pkg::HALF_TURN - 1) - rem_low;
        end else if (r3_big) begin
            n_word.angle = rem_low + bsc_pkg::RED_W'(1);
        end else begin
            n_word.angle = r3_tlow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r3_valid;
        end
        if (i_en) begin
            o_word <= n_word;
        end
    end

endmodule

/* rtl/core/bsc_frac.sv */
module bsc_frac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  bsc_pkg::t_red_word  i_word,
    output logic                o_valid,
    output bsc_pkg::t_frac_word o_word
);

    // stage 1: |radius|, sign, t*(180-t)
    logic [bsc_pkg::RED_W-1:0]  compl;
    logic [bsc_pkg::PROD_W-1:0] n_p;
    logic [bsc_pkg::MAG_W-1:0]  n_mag;

    assign compl = bsc_pkg::RED_W'(bsc_pkg::HALF_TURN) - i_word.angle;
    assign n_p   = bsc_pkg::PROD_W'(i_word.angle) * bsc_pkg::PROD_W'(compl);
    assign n_mag = i_word.radius[bsc_pkg::RADIUS_W-1] ?
                   bsc_pkg::MAG_W'(-i_word.radius) : bsc_pkg::MAG_W'(i_word.radius);

    logic                       r_valid;
    logic                       r_neg;
    logic [bsc_pkg::MAG_W-1:0]  r_mag;
    logic [bsc_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_neg <= i_word.radius[bsc_pkg::RADIUS_W-1] ^ i_word.flip;
            r_mag <= n_mag;
            r_p   <= n_p;
        end
    end

    // stage 2: numerator magnitude and denominator
    logic [bsc_pkg::NUM_W-1:0] n_prod;

    assign n_prod = bsc_pkg::NUM_W'(r_mag) * bsc_pkg::NUM_W'(r_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_valid;
        end
        if (i_en) begin
            o_word.neg     <= r_neg;
            o_word.num_mag <= n_prod << bsc_pkg::NUM_SHIFT;
            o_word.den     <= bsc_pkg::DEN_W'(bsc_pkg::DEN_BASE) - bsc_pkg::DEN_W'(r_p);
        end
    end

endmodule

/* rtl/core/bsc_div.sv */
module bsc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  bsc_pkg::t_frac_word i_word,
    output logic                o_valid,
    output bsc_pkg::t_div_word  o_word
);

    localparam int QW = bsc_pkg::QUO_W;

    // restoring divide, one quotient bit per stage, MSB first
    bsc_pkg::t_div_word r_st  [QW];
    logic               r_vld [QW];

    bsc_pkg::t_div_word first;

    always_comb begin
        first.neg = i_word.neg;
        first.rem = i_word.num_mag;
        first.den = i_word.den;
        first.quo = '0;
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        bsc_pkg::t_div_word        src;
        logic                      src_vld;
        logic [bsc_pkg::NUM_W-1:0] sh;
        logic                      ge;
        bsc_pkg::t_div_word        n_st;

        if (s == 0) begin : g_head
            assign src     = first;
            assign src_vld = i_valid;
        end else begin : g_body
            assign src     = r_st[s-1];
            assign src_vld = r_vld[s-1];
        end

        assign sh = bsc_pkg::NUM_W'(src.den) << (QW - 1 - s);
        assign ge = src.rem >= sh;

        always_comb begin
            n_st = src;
            if (ge) begin
                n_st.rem = src.rem - sh;
                n_st.quo[QW-1-s] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= src_vld;
            end
            if (i_en) begin
                r_st[s] <= n_st;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_word  = r_st[QW-1];

endmodule

/* rtl/core/bhaskara_sine_cosine.sv */
// channel | valid   | ready   | word
// input   | i_valid | o_ready | i_op, i_radius, i_angle_degrees
// output  | o_valid | i_ready | o_scaled_value
//
// One word per cycle while the output is not held; register stages: angle fold 4,
// fraction 2, restoring divide 17 (one quotient bit per stage), round 1.
// Synchronous active-low reset clears only the valid bits.
// The whole pipe advances together; it holds when the output register is
// full and not taken, so o_ready = !o_valid || i_ready.
module bhaskara_sine_cosine #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic signed [bsc_pkg::RADIUS_W-1:0] i_radius,
    input  logic signed [ANGLE_WIDTH-1:0]       i_angle_degrees,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bsc_pkg::OUT_W-1:0]    o_scaled_value
);

    logic en;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic                red_valid;
    bsc_pkg::t_red_word  red_word;
    logic                frac_valid;
    bsc_pkg::t_frac_word frac_word;
    logic                div_valid;
    bsc_pkg::t_div_word  div_word;

    bsc_reduce #(
        .ANGLE_WIDTH(ANGLE_WIDTH)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_radius(i_radius),
        .i_angle (i_angle_degrees),
        .o_valid (red_valid),
        .o_word  (red_word)
    );

    bsc_frac u_frac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(red_valid),
        .i_word (red_word),
        .o_valid(frac_valid),
        .o_word (frac_word)
    );

    bsc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(frac_valid),
        .i_word (frac_word),
        .o_valid(div_valid),
        .o_word (div_word)
    );

    // round away from zero when the remainder is at least den/2 (truncated); negative with zero quotient stays zero
    localparam int SW = bsc_pkg::SUM_W;
    localparam logic [SW-1:0] POS_MAX = SW'((1 << (bsc_pkg::OUT_W - 1)) - 1);
    localparam logic [SW-1:0] NEG_MAX = SW'(1 << (bsc_pkg::OUT_W - 1));

    logic                            rnd;
    logic [SW-1:0]                   mag;
    logic signed [bsc_pkg::OUT_W-1:0] n_value;

    assign rnd = div_word.rem[bsc_pkg::DEN_W-1:0] >= (div_word.den >> 1);
    assign mag = SW'(div_word.quo) + SW'(rnd);

    always_comb begin
        if (!div_word.neg) begin
            n_value = (mag > POS_MAX) ? bsc_pkg::OUT_W'(POS_MAX) : bsc_pkg::OUT_W'(mag);
        end else if (div_word.quo == '0) begin
            n_value = '0;
        end else if (mag > NEG_MAX) begin
            n_value = bsc_pkg::OUT_W'(-NEG_MAX);
        end else begin
            n_value = bsc_pkg::OUT_W'(-mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= div_valid;
        end
        if (en) begin
            o_scaled_value <= n_value;
        end
    end

endmodule

/* rtl/core/bsc_checker.sv */
module bsc_checker #(
    parameter int ANGLE_WIDTH = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                i_op,
    input logic signed [bsc_pkg::RADIUS_W-1:0] i_radius,
    input logic signed [ANGLE_WIDTH-1:0]       i_angle_degrees,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [bsc_pkg::OUT_W-1:0]    o_scaled_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_scaled_value))
        else $error("output word changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_op) && $stable(i_radius)
                                && $stable(i_angle_degrees))
        else $error("input word dropped or changed while waiting");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output register");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while pipe is held");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind bhaskara_sine_cosine bsc_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_bsc_checker (.*);

/* sim/bsc_checker.sv */
module bsc_scoreboard #(
    parameter int ANGLE_W = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_op,
    input  logic signed [bsc_pkg::RADIUS_W-1:0] i_radius,
    input  logic signed [ANGLE_W-1:0]           i_angle,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [bsc_pkg::OUT_W-1:0]    i_value,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_errors
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                                op;
        logic signed [bsc_pkg::RADIUS_W-1:0] radius;
        logic signed [ANGLE_W-1:0]           angle;
        logic signed [bsc_pkg::OUT_W-1:0]    value;
    } t_due;

    t_due scaled_due[$];
    int   due_count     = 0;
    int   checked_count = 0;
    int   error_count   = 0;

    assign o_pending = due_count;
    assign o_checked = checked_count;
    assign o_errors  = error_count;

    function automatic logic signed [bsc_pkg::OUT_W-1:0] bhaskara_scaled(
        input logic                                op,
        input logic signed [bsc_pkg::RADIUS_W-1:0] radius,
        input logic signed [ANGLE_W-1:0]           angle
    );
        longint r;
        longint t;
        longint turns;
        longint num;
        longint den;
        longint q;
        longint hi;
        longint lo;
        r = radius;
        t = angle;
        if (op == bsc_pkg::OP_COSINE) begin
            t = bsc_pkg::QUARTER_TURN - t;
        end
        turns = 0;
        if (t < 0) begin
            turns = (-t + bsc_pkg::HALF_TURN - 1) / bsc_pkg::HALF_TURN;
            t = t + turns * bsc_pkg::HALF_TURN;
        end else if (t > bsc_pkg::HALF_TURN) begin
            turns = (t - 1) / bsc_pkg::HALF_TURN;
            t = t - turns * bsc_pkg::HALF_TURN;
        end
        if (turns[0]) begin
            r = -r;
        end
        num = (r * t * (bsc_pkg::HALF_TURN - t)) <<< bsc_pkg::NUM_SHIFT;
        den = bsc_pkg::DEN_BASE - t * (bsc_pkg::HALF_TURN - t);
        q   = num / den;
        // negative numerator with zero quotient stays at zero, unrounded
        if (q >= 0) begin
            if (num >= 0 && (num % den) >= den / 2) begin
                q = q + 1;
            end
        end else if ((-num) % den >= den / 2) begin
            q = q - 1;
        end
        hi = (longint'(1) <<< (bsc_pkg::OUT_W - 1)) - 1;
        lo = -hi - 1;
        if (q > hi) begin
            q = hi;
        end
        if (q < lo) begin
            q = lo;
        end
        return q[bsc_pkg::OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_due word;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                word.op     = i_op;
                word.radius = i_radius;
                word.angle  = i_angle;
                word.value  = bhaskara_scaled(i_op, i_radius, i_angle);
                scaled_due.push_back(word);
            end
            if (i_out_valid && i_out_ready) begin
                if (scaled_due.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= 10) begin
                        $display("%t: result %0d with nothing outstanding", $realtime, i_value);
                    end
                end else begin
                    word = scaled_due.pop_front();
                    checked_count = checked_count + 1;
                    if (i_value !== word.value) begin
                        error_count = error_count + 1;
                        if (error_count <= 10) begin
                            $display("%t: mismatch op=%0d radius=%0d angle=%0d",
                                     $realtime, word.op, word.radius, word.angle);
                            $display("    expected %0d got %0d", word.value, i_value);
                        end
                    end
                end
            end
            due_count = scaled_due.size();
        end
    end

endmodule

/* sim/tb_bhaskara_sine_cosine.sv */
module tb_bhaskara_sine_cosine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_W    = 16;
    localparam int LONG_HOLD  = 160;
    localparam int QUIET_MAX  = 1500;
    localparam int TAIL       = 40;
    localparam int BLOCKS     = 17;
    localparam int BLOCK_SIZE = 100;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic                                in_op     = bsc_pkg::OP_SINE;
    logic signed [bsc_pkg::RADIUS_W-1:0] in_radius = '0;
    logic signed [ANGLE_W-1:0]           in_angle  = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [bsc_pkg::OUT_W-1:0]    out_value;

    int   pending;
    int   checked;
    int   errors;
    int   sent_count    = 0;
    int   cosine_count  = 0;
    int   quiet_cycles  = 0;
    bit   hold_request  = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bhaskara_sine_cosine #(
        .ANGLE_WIDTH(ANGLE_W)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_op           (in_op),
        .i_radius       (in_radius),
        .i_angle_degrees(in_angle),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_scaled_value (out_value)
    );

    bsc_scoreboard #(
        .ANGLE_W(ANGLE_W)
    ) checker_i (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_op       (in_op),
        .i_radius   (in_radius),
        .i_angle    (in_angle),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_value    (out_value),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_errors   (errors)
    );

    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic offer_word(input logic op, input int radius, input int angle, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_op     <= op;
        in_radius <= radius[bsc_pkg::RADIUS_W-1:0];
        in_angle  <= angle[ANGLE_W-1:0];
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        sent_count = sent_count + 1;
        if (op == bsc_pkg::OP_COSINE) begin
            cosine_count = cosine_count + 1;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_MAX) begin
                $display("timeout: %0d words sent, %0d outstanding", sent_count, pending);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : receiver
        int  run_left;
        bit  level;
        bit  held;
        run_left = 0;
        level    = 1'b0;
        held     = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request && !held) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                held     = 1'b1;
                run_left = 0;
                level    = 1'b0;
            end else begin
                if (run_left == 0) begin
                    level = !level;
                    if (level) begin
                        run_left = ($urandom_range(0, 9) < 2) ? $urandom_range(100, 300)
                                                               : $urandom_range(1, 20);
                    end else begin
                        run_left = idle_cycles() + 1;
                    end
                end
                out_ready <= level;
                run_left = run_left - 1;
            end
        end
    end

    initial begin : stimulus
        bit   burst;
        logic op;
        int   radius;
        int   angle;
        int   pick;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, both ops, folding boundaries, small negative quotient,
        // full-scale negative radius flipped into saturation
        offer_word(bsc_pkg::OP_SINE,   65535,   90,     0);
        offer_word(bsc_pkg::OP_SINE,   -65535,  90,     0);
        offer_word(bsc_pkg::OP_SINE,   -65536,  -90,    0);
        offer_word(bsc_pkg::OP_COSINE, -65536,  180,    idle_cycles());
        offer_word(bsc_pkg::OP_SINE,   -65536,  90,     0);
        offer_word(bsc_pkg::OP_SINE,   0,       45,     0);
        offer_word(bsc_pkg::OP_SINE,   1,       90,     idle_cycles());
        offer_word(bsc_pkg::OP_SINE,   -1,      1,      0);
        offer_word(bsc_pkg::OP_SINE,   -1,      179,    0);
        offer_word(bsc_pkg::OP_SINE,   1,       1,      0);
        offer_word(bsc_pkg::OP_SINE,   65535,   0,      idle_cycles());
        offer_word(bsc_pkg::OP_SINE,   65535,   180,    0);
        offer_word(bsc_pkg::OP_SINE,   65535,   181,    0);
        offer_word(bsc_pkg::OP_SINE,   65535,   -1,     0);
        offer_word(bsc_pkg::OP_SINE,   65535,   -180,   idle_cycles());
        offer_word(bsc_pkg::OP_SINE,   65535,   360,    0);
        offer_word(bsc_pkg::OP_SINE,   65535,   270,    0);
        offer_word(bsc_pkg::OP_SINE,   65535,   -32768, 0);
        offer_word(bsc_pkg::OP_SINE,   -65536,  32767,  idle_cycles());
        offer_word(bsc_pkg::OP_COSINE, 65535,   0,      0);
        offer_word(bsc_pkg::OP_COSINE, 65535,   -32768, 0);
        offer_word(bsc_pkg::OP_COSINE, -65535,  32767,  0);
        offer_word(bsc_pkg::OP_COSINE, 1000,    270,    idle_cycles());
        offer_word(bsc_pkg::OP_COSINE, -1,      89,     0);
        in_valid <= 1'b0;
        wait_drained();

        for (int blk = 0; blk < BLOCKS; blk++) begin
            burst = ($urandom_range(0, 9) < 3);
            if (blk == 4) begin
                in_valid <= 1'b0;
                @(negedge clk);
                hold_request = 1'b1;
                @(posedge clk);
                burst = 1'b1;
            end
            if (blk == 9) begin
                in_valid <= 1'b0;
                wait_drained();
            end
            for (int k = 0; k < BLOCK_SIZE; k++) begin
                op   = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    radius = int'($urandom_range(0, 131071)) - 65536;
                end else if (pick < 7) begin
                    radius = int'($urandom_range(0, 40)) - 20;
                end else begin
                    case ($urandom_range(0, 5))
                        0:       radius = 65535;
                        1:       radius = -65535;
                        2:       radius = -65536;
                        3:       radius = 1;
                        4:       radius = -1;
                        default: radius = 0;
                    endcase
                end
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    angle = int'($urandom_range(0, 65535)) - 32768;
                end else if (pick < 8) begin
                    angle = int'($urandom_range(0, 800)) - 400;
                end else begin
                    angle = (int'($urandom_range(0, 364)) - 182) * bsc_pkg::HALF_TURN
                            + int'($urandom_range(0, 2)) - 1;
                end
                offer_word(op, radius, angle, burst ? 0 : idle_cycles());
            end
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (TAIL) @(posedge clk);
        $display("covered %0d words (%0d sine, %0d cosine) incl. a long output stall and a drain",
                 sent_count, sent_count - cosine_count, cosine_count);
        $display("compared %0d results, %0d errors, %0d left outstanding",
                 checked, errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* bhaskara_sine_cosine.f */
rtl/core/bsc_pkg.sv
rtl/core/bsc_reduce.sv
rtl/core/bsc_frac.sv
rtl/core/bsc_div.sv
rtl/core/bhaskara_sine_cosine.sv
rtl/core/bsc_checker.sv
sim/bsc_checker.sv
sim/tb_bhaskara_sine_cosine.sv
